### rtl/core/hfb_pkg.sv
// Shared types, constants and sequencing codes of the host frame builder.
package hfb_pkg;

  // Field widths of the frame word stream.
  typedef logic [15:0] word_t;
  typedef logic [31:0] time_t;
  typedef logic [7:0]  len_t;
  typedef logic [8:0]  room_t;
  typedef logic [2:0]  step_t;

  // Ring capacity in words; room reported above it is clamped to it.
  localparam int unsigned TX_RING_WORDS  = 256;
  localparam int unsigned ROOM_W         = 17;
  localparam word_t       SYNC_WORD      = 16'hAC13;
  localparam int unsigned FRAME_OVERHEAD = 7;

  // Input item kinds.
  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // Result steps of an accepted header.
  localparam step_t STEP_SYNC    = 3'd0;
  localparam step_t STEP_COUNTER = 3'd1;
  localparam step_t STEP_OPCODE  = 3'd2;
  localparam step_t STEP_TIME_LO = 3'd3;
  localparam step_t STEP_TIME_HI = 3'd4;
  localparam step_t STEP_LEN     = 3'd5;
  localparam step_t STEP_HDR_CS  = 3'd6;

  // Result steps of a payload word.
  localparam step_t STEP_DATA    = 3'd0;
  localparam step_t STEP_DATA_CS = 3'd1;

  // What the sequencer has to emit for one transaction.
  typedef enum logic [1:0] {
    PLAN_REJECT,
    PLAN_HEADER,
    PLAN_DATA
  } plan_kind_t;

  typedef struct packed {
    plan_kind_t kind;
    logic       close;
    word_t      opcode;
    time_t      time_tag;
    len_t       payload_len;
    word_t      data_word;
    word_t      frame_cnt;
    word_t      misses;
    word_t      done;
  } plan_t;

endpackage

### rtl/core/hfb_if.sv
// Valid/ready channel interfaces for the input items and the frame words.
interface hfb_in_if
  import hfb_pkg::*;
();
  logic  valid;
  logic  ready;
  logic  kind;
  word_t opcode;
  time_t time_tag;
  len_t  payload_len;
  room_t free_words;
  word_t data_word;

  modport source (
    output valid, kind, opcode, time_tag, payload_len, free_words, data_word,
    input  ready
  );
  modport sink (
    input  valid, kind, opcode, time_tag, payload_len, free_words, data_word,
    output ready
  );
endinterface

interface hfb_out_if
  import hfb_pkg::*;
();
  logic  valid;
  logic  ready;
  word_t frame_word;
  logic  end_of_frame;
  logic  rejected;
  word_t miss_count;
  word_t sent_count;

  modport source (
    output valid, frame_word, end_of_frame, rejected, miss_count, sent_count,
    input  ready
  );
  modport sink (
    input  valid, frame_word, end_of_frame, rejected, miss_count, sent_count,
    output ready
  );
endinterface

### rtl/core/host_frame_builder_sum_checksum_unit.sv
// Host frame builder: header, payload pass-through and 16-bit sum checksum.
//
//   Channel   Direction  Transaction
//   in_chan   sink       start item (opcode, time, length, room) or payload word
//   out_chan  source     one frame word with end/reject flags and counters
//
// Each transaction yields one result per cycle unless the output stalls: a start item
// yields six words, seven for a zero length frame and one when refused; a payload
// word yields one, two when it closes the frame, and none when it is discarded.
// The rate is set by the single output register, which moves one frame word per
// cycle when not stalled; the next item is taken in the cycle its predecessor's last
// word leaves the sequencer. Reset is synchronous and active low and clears all
// counters and control state. A stalled output holds its word and the sequencer.
module host_frame_builder_sum_checksum_unit
  import hfb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  hfb_in_if.sink    in_chan,
  hfb_out_if.source out_chan
);

  // Architectural frame state, updated as each transaction is accepted.
  word_t frame_counter_r, frame_counter_nxt;
  len_t  words_left_r, words_left_nxt;
  logic  frame_open_r, frame_open_nxt;
  logic  frame_dropping_r, frame_dropping_nxt;
  word_t misses_r, misses_nxt;
  word_t frames_done_r, frames_done_nxt;

  // Running sum of emitted frame words, kept in the sequencer.
  word_t sum_acc_r, sum_acc_nxt;

  // Sequencer plan register.
  plan_t plan_r, plan_nxt;
  logic  plan_valid_r, plan_valid_nxt;
  step_t step_r, step_nxt;

  // Output register.
  logic  out_valid_r;
  word_t out_word_r;
  logic  out_eof_r;
  logic  out_rej_r;
  word_t out_miss_r;
  word_t out_sent_r;

  logic  in_fire;
  logic  emit;
  logic  plan_done;
  step_t last_step;
  logic  load_plan;

  logic [ROOM_W-1:0] room_clamped;
  logic              reject;

  word_t res_word;
  logic  res_eof;
  logic  res_rej;
  word_t res_sent;
  logic  res_is_cs;
  logic  res_restart;

  // Last step of the current plan.
  always_comb begin
    unique case (plan_r.kind)
      PLAN_REJECT: last_step = STEP_SYNC;
      PLAN_HEADER: last_step = plan_r.close ? STEP_HDR_CS : STEP_LEN;
      PLAN_DATA:   last_step = plan_r.close ? STEP_DATA_CS : STEP_DATA;
      default:     last_step = STEP_SYNC;
    endcase
  end

  // Handshake: a new item enters when the sequencer is empty or finishing.
  assign emit      = plan_valid_r && (!out_valid_r || out_chan.ready);
  assign plan_done = emit && (step_r == last_step);
  assign in_chan.ready = !plan_valid_r || plan_done;
  assign in_fire   = in_chan.valid && in_chan.ready;

  // Room check with the ring clamp.
  always_comb begin
    room_clamped = ROOM_W'(in_chan.free_words);
    if (room_clamped > ROOM_W'(TX_RING_WORDS)) begin
      room_clamped = ROOM_W'(TX_RING_WORDS);
    end
    reject = room_clamped < (ROOM_W'(in_chan.payload_len) + ROOM_W'(FRAME_OVERHEAD));
  end

  // Decode of an accepted transaction into the state update and a plan.
  always_comb begin
    frame_counter_nxt  = frame_counter_r;
    words_left_nxt     = words_left_r;
    frame_open_nxt     = frame_open_r;
    frame_dropping_nxt = frame_dropping_r;
    misses_nxt         = misses_r;
    frames_done_nxt    = frames_done_r;
    load_plan          = 1'b0;

    plan_nxt             = plan_r;
    plan_nxt.opcode      = in_chan.opcode;
    plan_nxt.time_tag    = in_chan.time_tag;
    plan_nxt.payload_len = in_chan.payload_len;
    plan_nxt.data_word   = in_chan.data_word;
    plan_nxt.frame_cnt   = frame_counter_r;
    plan_nxt.done        = frames_done_r;
    plan_nxt.close       = 1'b0;
    plan_nxt.kind        = PLAN_DATA;

    if (in_fire) begin
      if (in_chan.kind == KIND_START) begin
        frame_open_nxt     = 1'b0;
        frame_dropping_nxt = 1'b0;
        words_left_nxt     = in_chan.payload_len;
        load_plan          = 1'b1;
        if (reject) begin
          misses_nxt         = misses_r + 16'd1;
          frame_dropping_nxt = (in_chan.payload_len != '0);
          plan_nxt.kind      = PLAN_REJECT;
        end else begin
          frame_counter_nxt = frame_counter_r + 16'd1;
          plan_nxt.kind     = PLAN_HEADER;
          if (in_chan.payload_len == '0) begin
            plan_nxt.close  = 1'b1;
            frames_done_nxt = frames_done_r + 16'd1;
          end else begin
            frame_open_nxt  = 1'b1;
          end
        end
      end else if (frame_open_r) begin
        words_left_nxt = words_left_r - 8'd1;
        load_plan      = 1'b1;
        plan_nxt.kind  = PLAN_DATA;
        if (words_left_nxt == '0) begin
          plan_nxt.close  = 1'b1;
          frame_open_nxt  = 1'b0;
          frames_done_nxt = frames_done_r + 16'd1;
        end
      end else if (frame_dropping_r) begin
        // A refused frame's payload is swallowed without results.
        words_left_nxt = words_left_r - 8'd1;
        if (words_left_nxt == '0) begin
          frame_dropping_nxt = 1'b0;
        end
      end
    end
    plan_nxt.misses = misses_nxt;
  end

  // Result selection for the current step.
  always_comb begin
    res_word    = ~sum_acc_r + 16'd1;
    res_eof     = 1'b0;
    res_rej     = 1'b0;
    res_sent    = plan_r.done;
    res_is_cs   = 1'b0;
    res_restart = 1'b0;
    unique case (plan_r.kind)
      PLAN_REJECT: begin
        res_word = '0;
        res_eof  = 1'b1;
        res_rej  = 1'b1;
      end
      PLAN_HEADER: begin
        case (step_r)
          STEP_SYNC: begin
            res_word    = SYNC_WORD;
            res_restart = 1'b1;
          end
          STEP_COUNTER: res_word = plan_r.frame_cnt;
          STEP_OPCODE:  res_word = plan_r.opcode;
          STEP_TIME_LO: res_word = plan_r.time_tag[15:0];
          STEP_TIME_HI: res_word = plan_r.time_tag[31:16];
          STEP_LEN:     res_word = {plan_r.payload_len, 1'b0} + 16'd0;
          default: begin
            res_is_cs = 1'b1;
            res_eof   = 1'b1;
            res_sent  = plan_r.done + 16'd1;
          end
        endcase
      end
      PLAN_DATA: begin
        if (step_r == STEP_DATA) begin
          res_word = plan_r.data_word;
        end else begin
          res_is_cs = 1'b1;
          res_eof   = 1'b1;
          res_sent  = plan_r.done + 16'd1;
        end
      end
      default: begin
        res_word = '0;
      end
    endcase
  end

  // Checksum accumulator and sequencer step.
  always_comb begin
    sum_acc_nxt    = sum_acc_r;
    step_nxt       = step_r;
    plan_valid_nxt = plan_valid_r;
    if (emit) begin
      if (res_restart) begin
        sum_acc_nxt = res_word;
      end else if (!res_is_cs && !res_rej) begin
        sum_acc_nxt = sum_acc_r + res_word;
      end
      step_nxt = step_r + 3'd1;
    end
    if (plan_done) begin
      plan_valid_nxt = 1'b0;
    end
    if (load_plan) begin
      plan_valid_nxt = 1'b1;
      step_nxt       = STEP_SYNC;
    end
  end

  // Control and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_counter_r  <= '0;
      words_left_r     <= '0;
      frame_open_r     <= 1'b0;
      frame_dropping_r <= 1'b0;
      misses_r         <= '0;
      frames_done_r    <= '0;
      sum_acc_r        <= '0;
      plan_valid_r     <= 1'b0;
      step_r           <= STEP_SYNC;
      out_valid_r      <= 1'b0;
    end else begin
      frame_counter_r  <= frame_counter_nxt;
      words_left_r     <= words_left_nxt;
      frame_open_r     <= frame_open_nxt;
      frame_dropping_r <= frame_dropping_nxt;
      misses_r         <= misses_nxt;
      frames_done_r    <= frames_done_nxt;
      sum_acc_r        <= sum_acc_nxt;
      plan_valid_r     <= plan_valid_nxt;
      step_r           <= step_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: plan and output word.
  always_ff @(posedge clk) begin
    if (load_plan) begin
      plan_r <= plan_nxt;
    end
    if (emit) begin
      out_word_r <= res_word;
      out_eof_r  <= res_eof;
      out_rej_r  <= res_rej;
      out_miss_r <= plan_r.misses;
      out_sent_r <= res_sent;
    end
  end

  // Output channel.
  assign out_chan.valid        = out_valid_r;
  assign out_chan.frame_word   = out_word_r;
  assign out_chan.end_of_frame = out_eof_r;
  assign out_chan.rejected     = out_rej_r;
  assign out_chan.miss_count   = out_miss_r;
  assign out_chan.sent_count   = out_sent_r;

  // The sequencer never stands beyond the last step of its plan.
  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    plan_valid_r |-> (step_r <= last_step))
    else $error("sequencer step beyond the end of its plan");

  // An empty sequencer always takes the next transaction.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !plan_valid_r |-> in_chan.ready)
    else $error("input stalled with an empty sequencer");

  // A refused frame shows as a closing zero word.
  a_reject_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rej_r) |-> (out_eof_r && (out_word_r == '0)))
    else $error("reject result without end flag or with a non-zero word");

  // A frame is never open and dropping at the same time.
  a_open_xor_drop: assert property (@(posedge clk) disable iff (!rst_n)
    !(frame_open_r && frame_dropping_r))
    else $error("frame both open and dropping");

endmodule
